>>> sv/sjf_srt_ready_scheduler_unit_assert.svh
// Assertion macros for the ready-table scheduler.
`ifndef SJF_SRT_READY_SCHEDULER_UNIT_ASSERT_SVH
`define SJF_SRT_READY_SCHEDULER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/srs_pkg.sv
// Package: types, constants and helpers of the ready-table scheduler.
`default_nettype none
package srs_pkg;
  localparam int unsigned READY_DEPTH_DEF = 32;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_SRT  = 2'd2;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_PREEMPT  = 2'd2;
  localparam logic [1:0] ACT_DROP     = 2'd3;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  // tail write sources
  localparam logic [1:0] PUSH_IN   = 2'd0;
  localparam logic [1:0] PUSH_RUN  = 2'd1;
  localparam logic [1:0] PUSH_TAKE = 2'd2;

  // result payload sources
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_IN   = 2'd1;
  localparam logic [1:0] SRC_TAKE = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] task_id;
    logic [31:0] estimate_in;
    logic [23:0] actual_burst;
    logic        requeue;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] chosen_id;
    logic [31:0] chosen_estimate;
    logic [5:0]  ready_count;
  } out_item_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic push;       // write push_sel entry at tail, count++
    logic [1:0] push_sel; // PUSH_IN, PUSH_RUN (updated), PUSH_TAKE
    logic scan_start; // clear best index, start scan pointer at 0
    logic scan_step;  // compare entry at scan pointer, advance
    logic rd_best;    // read best entry into take register
    logic shift_start;
    logic shift_step; // move entry ptr+1 to ptr
    logic shift_done; // count--
    logic pick_tail;  // best = count-1
    logic upd_start;  // start estimate multiply
    logic run_from_take;
    logic run_from_pend;
    logic pend_from_take;
    logic run_clear;
    logic pend_clear;
    logic [1:0] out_act;
    logic [1:0] out_src; // SRC_ZERO, SRC_IN, SRC_TAKE
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic count_full;  // count >= depth
    logic count_over;  // count > depth
    logic count_zero;
    logic scan_done;
    logic shift_done;
    logic upd_done;
    logic take_lt_run; // take est < running est
    logic running_valid;
    logic pending_valid;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> sv/srs_datapath.sv
// Datapath: ready table memory, scan/compact pointers, running/pending regs.
`default_nettype none
module srs_datapath #(
  parameter int unsigned READY_DEPTH = srs_pkg::READY_DEPTH_DEF,
  localparam int unsigned AW = $clog2(READY_DEPTH + 1),
  localparam int unsigned CW = $clog2(READY_DEPTH + 2)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire srs_pkg::in_item_t    item,
  input  wire logic [1:0]           policy,
  input  wire logic [8:0]           weight,
  input  wire srs_pkg::dp_cmd_t     cmd,
  output srs_pkg::dp_sts_t          sts,
  output srs_pkg::out_item_t        result
);
  logic [47:0] mem [READY_DEPTH + 1];
  logic [CW-1:0] count;
  logic [AW-1:0] ptr, best;
  logic [47:0] rd_data, take;
  logic [31:0] best_est;
  logic        rd_phase;
  logic [15:0] run_id, pend_id;
  logic [31:0] run_est, pend_est;
  logic        run_vld, pend_vld;
  logic [31:0] upd_est;
  logic [40:0] prod_a, prod_b;
  logic [1:0]  upd_cnt;
  logic [47:0] wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic        wr_en;
  logic        use_est;
  logic [8:0]  w_sat;

  assign use_est = (policy == srs_pkg::POL_SJF) || (policy == srs_pkg::POL_SRT);
  assign w_sat = (weight > 9'd256) ? 9'd256 : weight;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {item.task_id, item.estimate_in};
    if (cmd.push) begin
      wr_en = 1'b1;
      case (cmd.push_sel)
        srs_pkg::PUSH_RUN: wr_data = {run_id, use_est ? upd_est : run_est};
        srs_pkg::PUSH_TAKE: wr_data = take;
        default: wr_data = {item.task_id, item.estimate_in};
      endcase
    end else if (cmd.shift_step && rd_phase) begin
      wr_en = 1'b1;
      wr_addr = ptr;
      wr_data = rd_data;
    end
  end

  // read address: scan pointer, shift source, or best
  always_comb begin
    if (cmd.rd_best) rd_addr = best;
    else if (cmd.shift_step) rd_addr = ptr + AW'(1);
    else rd_addr = ptr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; ptr <= '0; best <= '0; rd_phase <= 1'b0;
      run_vld <= 1'b0; pend_vld <= 1'b0; upd_cnt <= '0;
      run_id <= '0; run_est <= '0; pend_id <= '0; pend_est <= '0;
    end else begin
      if (cmd.push) count <= count + CW'(1);
      if (cmd.shift_done) count <= count - CW'(1);
      if (cmd.pick_tail) best <= AW'(count - CW'(1));
      if (cmd.scan_start) begin
        best <= '0; ptr <= '0; rd_phase <= 1'b0;
      end
      if (cmd.scan_step) begin
        // phase 0 issues read, phase 1 compares
        rd_phase <= ~rd_phase;
        if (rd_phase) begin
          if (ptr == '0) best_est <= rd_data[31:0];
          else if (use_est && rd_data[31:0] < best_est) begin
            best <= ptr; best_est <= rd_data[31:0];
          end
          ptr <= ptr + AW'(1);
        end
      end
      if (cmd.rd_best) take <= mem[best];
      if (cmd.shift_start) begin
        ptr <= best; rd_phase <= 1'b0;
      end
      if (cmd.shift_step) begin
        rd_phase <= ~rd_phase;
        if (rd_phase) ptr <= ptr + AW'(1);
      end
      // 9x32 products: old-estimate term first, burst term once item is held
      if (cmd.upd_start) begin
        upd_cnt <= 2'd2;
        prod_a <= '0;
        prod_b <= 41'(9'd256 - w_sat) * 41'(run_est);
      end else if (upd_cnt != 2'd0) begin
        upd_cnt <= upd_cnt - 2'd1;
        if (upd_cnt == 2'd2)
          prod_a <= 41'(w_sat) * 41'({item.actual_burst, 8'h0});
        else
          upd_est <= 32'((prod_a + prod_b) >> 8);
      end
      if (cmd.run_from_take) begin
        run_id <= take[47:32]; run_est <= take[31:0]; run_vld <= 1'b1;
      end
      if (cmd.run_from_pend) begin
        run_id <= pend_id; run_est <= pend_est; run_vld <= 1'b1;
      end
      if (cmd.run_clear) run_vld <= 1'b0;
      if (cmd.pend_from_take) begin
        pend_id <= take[47:32]; pend_est <= take[31:0]; pend_vld <= 1'b1;
      end
      if (cmd.pend_clear) pend_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.action <= cmd.out_act;
      case (cmd.out_src)
        srs_pkg::SRC_IN: begin
          result.chosen_id <= item.task_id;
          result.chosen_estimate <= item.estimate_in;
        end
        srs_pkg::SRC_TAKE: begin
          result.chosen_id <= take[47:32];
          result.chosen_estimate <= take[31:0];
        end
        default: begin
          result.chosen_id <= '0;
          result.chosen_estimate <= '0;
        end
      endcase
      // a tail write in the same cycle counts toward the reported fill
      result.ready_count <= cmd.push ? 6'(count + CW'(1)) : 6'(count);
    end
  end

  always_comb begin
    sts.count_full = (count >= CW'(READY_DEPTH));
    sts.count_over = (count > CW'(READY_DEPTH));
    sts.count_zero = (count == '0);
    sts.scan_done = (CW'(ptr) >= count);
    sts.shift_done = (CW'(ptr) + CW'(1) >= count);
    sts.upd_done = (upd_cnt == 2'd0);
    sts.take_lt_run = (take[31:0] < run_est);
    sts.running_valid = run_vld;
    sts.pending_valid = pend_vld;
  end
endmodule
`default_nettype wire

>>> sv/srs_ctrl.sv
// Controller state machine of the ready-table scheduler.
`default_nettype none
module srs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire srs_pkg::in_item_t item,
  input  wire logic [1:0]        policy,
  input  wire srs_pkg::dp_sts_t  sts,
  input  wire logic              out_taken,
  output srs_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   out_full
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_TAKE  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_DECIDE= 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;
  localparam logic [3:0] S_END2  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_TAKE0 = 4'd10;

  logic [3:0] state, state_next;
  logic       is_add, is_add_next, tail_drop, tail_drop_next;
  logic       took, took_next;
  logic       full, full_next;
  logic       out_hold;

  assign busy = (state != S_IDLE);
  assign out_full = full;
  // previous result still waiting: no new load yet
  assign out_hold = full && !out_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; is_add <= 1'b0; tail_drop <= 1'b0; full <= 1'b0;
      took <= 1'b0;
    end else begin
      state <= state_next; is_add <= is_add_next;
      tail_drop <= tail_drop_next; full <= full_next;
      took <= took_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    is_add_next = is_add;
    tail_drop_next = tail_drop;
    took_next = took;
    full_next = full && !out_taken;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          is_add_next = !item.cmd;
          took_next = 1'b0;
          state_next = item.cmd ? S_UPD : S_ADD;
          if (item.cmd) cmd.upd_start = 1'b1;
        end
      end
      S_ADD: begin
        if (sts.count_full) begin
          if (!out_hold) begin
            cmd.out_load = 1'b1; cmd.out_act = srs_pkg::ACT_DROP;
            cmd.out_src = srs_pkg::SRC_IN; state_next = S_OUT;
          end
        end else begin
          cmd.push = 1'b1;
          if (!sts.running_valid || policy == srs_pkg::POL_SRT) begin
            cmd.scan_start = 1'b1; state_next = S_SCAN;
          end else begin
            state_next = S_DECIDE;
          end
        end
      end
      S_UPD: if (sts.upd_done) state_next = S_END;
      S_END: begin
        if (sts.running_valid) begin
          if (item.requeue) begin
            cmd.push = 1'b1; cmd.push_sel = srs_pkg::PUSH_RUN;
          end
          cmd.run_clear = 1'b1;
        end
        state_next = S_END2;
      end
      S_END2: begin
        tail_drop_next = 1'b0;
        if (sts.pending_valid) begin
          cmd.run_from_pend = 1'b1; cmd.pend_clear = 1'b1;
          if (sts.count_over) begin
            cmd.pick_tail = 1'b1; tail_drop_next = 1'b1; state_next = S_TAKE0;
          end else state_next = S_DECIDE;
        end else if (!sts.running_valid && !sts.count_zero) begin
          cmd.scan_start = 1'b1; state_next = S_SCAN;
        end else state_next = S_DECIDE;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          took_next = 1'b1; state_next = S_TAKE0;
        end else cmd.scan_step = 1'b1;
      end
      S_TAKE0: begin
        cmd.rd_best = 1'b1; state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.shift_start = 1'b1; state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.shift_done = 1'b1; state_next = S_DECIDE;
        end else cmd.shift_step = 1'b1;
      end
      S_DECIDE: begin
        if (!out_hold) begin
          cmd.out_load = 1'b1; state_next = S_OUT;
          if (tail_drop) begin
            cmd.out_act = srs_pkg::ACT_DROP; cmd.out_src = srs_pkg::SRC_TAKE;
            tail_drop_next = 1'b0;
          end else if (is_add && sts.running_valid
                       && policy == srs_pkg::POL_SRT) begin
            if (!sts.pending_valid && sts.take_lt_run) begin
              cmd.out_act = srs_pkg::ACT_PREEMPT; cmd.out_src = srs_pkg::SRC_TAKE;
              cmd.pend_from_take = 1'b1;
            end else begin
              // losing candidate goes back to the tail
              cmd.push = 1'b1; cmd.push_sel = srs_pkg::PUSH_TAKE;
            end
          end else if (!sts.running_valid && took) begin
            cmd.out_act = srs_pkg::ACT_DISPATCH; cmd.out_src = srs_pkg::SRC_TAKE;
            cmd.run_from_take = 1'b1;
          end
        end
      end
      S_OUT: begin
        full_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/sjf_srt_ready_scheduler_unit.sv
// Top level: ready-table scheduler, FIFO / SJF / preemptive SRT policies.
`default_nettype none
// One transaction in, one result out, handled one at a time. A transaction
// is accepted whenever the controller is idle, even while the previous
// result still waits in the output register; the new result is held back
// until that register is taken. An add that dispatches or is checked for
// preemption first scans the table for the chosen entry, reads it, then
// compacts the entries behind it; a burst end that dispatches runs the
// registered estimate multiply before those steps. The scan reads one
// entry at a time through the registered read port of the table memory;
// FIFO always takes the head, so every entry behind it is moved. The next
// transaction can be accepted in the same cycle that out_valid rises, even
// while out_ready is low.
`include "sjf_srt_ready_scheduler_unit_assert.svh"
module sjf_srt_ready_scheduler_unit #(
  parameter int unsigned READY_DEPTH = srs_pkg::READY_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srs_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [8:0]         cfg_data
);
  logic [1:0] policy;
  logic [8:0] weight;
  srs_pkg::in_item_t item;
  srs_pkg::dp_cmd_t cmd;
  srs_pkg::dp_sts_t sts;
  logic busy, in_fire, out_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= srs_pkg::POL_FIFO; weight <= 9'd128;
    end else if (cfg_we) begin
      if (cfg_index == srs_pkg::REG_POLICY) policy <= cfg_data[1:0];
      else weight <= cfg_data;
    end
  end

  // accept whenever the controller is idle; a waiting result only delays
  // the load of the next one
  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign out_taken = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (in_fire) item <= in_data;
  end

  srs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .item(in_fire ? in_data : item), .policy, .sts,
    .out_taken, .cmd, .busy, .out_full(out_valid)
  );

  srs_datapath #(.READY_DEPTH(READY_DEPTH)) u_dp (
    .clk, .rst, .item, .policy, .weight, .cmd, .sts, .result(out_data)
  );

  `SRS_ASSERT_IMP(a_no_accept_busy, busy, !in_ready)
  `SRS_ASSERT_NXT(a_fire_busy, in_fire, busy)
  `SRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
`default_nettype wire
